FILE: rtl/core/cfp_pkg.sv
package cfp_pkg;

  // frame markers, either case
  localparam logic [7:0] CH_P_UP = 8'h50;
  localparam logic [7:0] CH_P_LO = 8'h70;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_M_UP = 8'h4D;
  localparam logic [7:0] CH_M_LO = 8'h6D;
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_R_LO = 8'h72;

  // request byte codes
  localparam logic [7:0] REQ_STATUS = 8'd1;
  localparam logic [7:0] REQ_MEMORY = 8'd2;

  // triple position
  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_SUB   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_GOT_P   = 3'd1,
    ST_GOT_A   = 3'd2,
    ST_GOT_LEN = 3'd3,
    ST_GOT_SRC = 3'd4,
    ST_GOT_DST = 3'd5,
    ST_BODY    = 3'd6,
    ST_AFTER_M = 3'd7
  } parse_state_t;

  typedef struct packed {
    logic       indicator_on;
    logic       setting_valid;
    logic [7:0] device_code;
    logic [7:0] device_sub;
    logic [7:0] device_value;
    logic       frame_done;
    logic       reply_status;
    logic       reply_memory;
  } result_t;

endpackage

FILE: rtl/core/cfp_parse.sv
module cfp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        room_address,
  output cfp_pkg::result_t  result
);

  cfp_pkg::parse_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] sub_r, sub_nxt;
  logic       status_r, status_nxt;
  logic       memory_r, memory_nxt;
  logic       ind_r, ind_nxt;

  logic is_p, is_a, is_m, is_r, take_body;

  assign is_p = (rx_byte == cfp_pkg::CH_P_UP) || (rx_byte == cfp_pkg::CH_P_LO);
  assign is_a = (rx_byte == cfp_pkg::CH_A_UP) || (rx_byte == cfp_pkg::CH_A_LO);
  assign is_m = (rx_byte == cfp_pkg::CH_M_UP) || (rx_byte == cfp_pkg::CH_M_LO);
  assign is_r = (rx_byte == cfp_pkg::CH_R_UP) || (rx_byte == cfp_pkg::CH_R_LO);

  // body byte goes into the triple in body state, or after m unless it closes
  assign take_body = (state_r == cfp_pkg::ST_BODY) ||
                     ((state_r == cfp_pkg::ST_AFTER_M) && !is_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfp_pkg::ST_IDLE:    if (is_p) state_nxt = cfp_pkg::ST_GOT_P;
      cfp_pkg::ST_GOT_P:   state_nxt = is_a ? cfp_pkg::ST_GOT_A : cfp_pkg::ST_IDLE;
      cfp_pkg::ST_GOT_A:   state_nxt = cfp_pkg::ST_GOT_LEN;
      cfp_pkg::ST_GOT_LEN: state_nxt = cfp_pkg::ST_GOT_SRC;
      cfp_pkg::ST_GOT_SRC: begin
        state_nxt = (rx_byte == room_address) ? cfp_pkg::ST_GOT_DST : cfp_pkg::ST_IDLE;
      end
      cfp_pkg::ST_GOT_DST: state_nxt = cfp_pkg::ST_BODY;
      cfp_pkg::ST_BODY:    if (is_m) state_nxt = cfp_pkg::ST_AFTER_M;
      cfp_pkg::ST_AFTER_M: state_nxt = is_r ? cfp_pkg::ST_IDLE : cfp_pkg::ST_BODY;
      default:             state_nxt = cfp_pkg::ST_IDLE;
    endcase
  end

  // held fields, flags and per-byte result
  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    sub_nxt    = sub_r;
    status_nxt = status_r;
    memory_nxt = memory_r;
    ind_nxt    = ind_r;
    result     = '0;

    if (state_r == cfp_pkg::ST_GOT_SRC) begin
      ind_nxt = (rx_byte == room_address);
    end

    if (state_r == cfp_pkg::ST_GOT_DST) begin
      status_nxt = (rx_byte == cfp_pkg::REQ_STATUS);
      memory_nxt = (rx_byte == cfp_pkg::REQ_MEMORY);
      phase_nxt  = cfp_pkg::PH_CODE;
    end

    if (take_body) begin
      case (phase_r)
        cfp_pkg::PH_CODE: begin
          code_nxt  = rx_byte;
          phase_nxt = cfp_pkg::PH_SUB;
        end
        cfp_pkg::PH_SUB: begin
          sub_nxt   = rx_byte;
          phase_nxt = cfp_pkg::PH_VALUE;
        end
        cfp_pkg::PH_VALUE: begin
          result.setting_valid = 1'b1;
          result.device_code   = code_r;
          result.device_sub    = sub_r;
          result.device_value  = rx_byte;
          phase_nxt            = cfp_pkg::PH_CODE;
        end
        default: phase_nxt = phase_r;
      endcase
    end

    // closing r after m
    if ((state_r == cfp_pkg::ST_AFTER_M) && is_r) begin
      result.frame_done   = 1'b1;
      result.reply_status = status_r;
      result.reply_memory = memory_r;
    end

    result.indicator_on = ind_nxt;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cfp_pkg::ST_IDLE;
      phase_r  <= cfp_pkg::PH_CODE;
      code_r   <= '0;
      sub_r    <= '0;
      status_r <= 1'b0;
      memory_r <= 1'b0;
      ind_r    <= 1'b0;
    end else if (step) begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      sub_r    <= sub_nxt;
      status_r <= status_nxt;
      memory_r <= memory_nxt;
      ind_r    <= ind_nxt;
    end
  end

endmodule

FILE: rtl/core/cfp_out_reg.sv
module cfp_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic                                unload,
  input  cfp_pkg::result_t                    result,
  output logic                                valid,
  output logic [cfp_pkg::OUT_TDATA_W-1:0]     tdata,
  output logic                                tuser,
  output logic                                tlast
);

  logic             valid_r;
  cfp_pkg::result_t res_r;

  // valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (unload) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign valid = valid_r;
  assign tuser = res_r.setting_valid;
  assign tlast = res_r.frame_done;

  // pack tdata, highest field first, indicator_on in bit 0
  assign tdata = {5'd0, res_r.reply_memory, res_r.reply_status, res_r.device_value,
                  res_r.device_sub, res_r.device_code, res_r.indicator_on};

endmodule

FILE: rtl/core/command_frame_parser.sv
// Command frame parser: one received serial byte per transfer on the in_
// channel, one result per byte on the out_ channel.
// A frame is P A (either case), length, source, destination, request, then
// body bytes grouped into code/sub/value triples; M then R closes it.
// out_tdata holds the indicator level, the last triple and the reply flags;
// out_tuser marks a completed triple, out_tlast marks the closing R.
// cfg_ carries the room address; a write is taken at once (cfg_ready high)
// and must only happen while no byte is in flight.
// An in_ transfer reaches its result on out_ through the input register, then
// parse logic into the result register.
// Throughput: one byte per cycle while out_tready stays high; the single
// parse state update per byte between the two registers sets this figure.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to idle and clears the flags, held bytes and room address.
// With a result waiting and out_tready low, the result register holds; the
// input register takes one more byte only if empty, then in_tready drops.
module command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] indicator_on, [8:1] device_code,
                                  // [16:9] device_sub, [24:17] device_value,
                                  // [25] reply_status, [26] reply_memory
  output logic        out_tuser,  // [0] setting_valid
  output logic        out_tlast,  // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // room_address
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic [7:0]       room_r;
  logic             advance;
  logic             out_valid;
  cfp_pkg::result_t result;

  // input register moves on when the result register is free or draining
  assign advance   = !out_valid || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // room address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      room_r <= cfg_data;
    end
  end

  cfp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_valid_r && advance),
    .rx_byte      (in_byte_r),
    .room_address (room_r),
    .result       (result)
  );

  cfp_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_valid_r && advance),
    .unload (out_tready),
    .result (result),
    .valid  (out_valid),
    .tdata  (out_tdata),
    .tuser  (out_tuser),
    .tlast  (out_tlast)
  );

  assign out_tvalid = out_valid;

endmodule
